[rtl/aesbe_pkg.sv]
// shared types, constants and byte functions of the aes block encryptor
package aesbe_pkg;

	localparam int KeyRegW = 64;
	localparam int NumCfgRegs = 5;
	localparam int CfgIdxW = 3;
	localparam int KeyLenW = 2;
	localparam int NumCols = 4;
	localparam int RkDepth = 30;
	localparam int RkIdxW = 5;

	localparam logic [CfgIdxW-1:0] RegKey0 = 3'd0;
	localparam logic [CfgIdxW-1:0] RegKey1 = 3'd1;
	localparam logic [CfgIdxW-1:0] RegKey2 = 3'd2;
	localparam logic [CfgIdxW-1:0] RegKey3 = 3'd3;
	localparam logic [CfgIdxW-1:0] RegKeyLen = 3'd4;

	localparam logic [KeyLenW-1:0] Len128 = 2'd0;
	localparam logic [KeyLenW-1:0] Len192 = 2'd1;
	localparam logic [KeyLenW-1:0] Len256 = 2'd2;
	localparam logic [KeyLenW-1:0] LenSpare = 2'd3;

	// control handed to every column cell
	typedef struct packed {
		logic load;
		logic step;
		logic mix;
	} col_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEXP = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
			8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
			8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
			8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
			8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
			8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
			8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
			8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
			8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
			8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
			8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
			8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
			8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
			8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
			8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
			8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
			8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
		};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

[rtl/aesbe_col_cell.sv]
// one state column cell: sbox of its shifted bytes, mixcolumns and round key add
module aesbe_col_cell (
	input  logic                clk,
	input  aesbe_pkg::col_ctrl_t ctrl,
	input  logic [31:0]         load_col,
	// byte r of column c+r, gathered from the neighbouring cells
	input  logic [31:0]         shift_col,
	input  logic [31:0]         rkey,
	output logic [31:0]         col_q
);
	import aesbe_pkg::*;

	logic [7:0] s0, s1, s2, s3, all, m0, m1, m2, m3;
	logic [31:0] nxt;

	always_comb begin
		s0 = sbox(shift_col[31:24]);
		s1 = sbox(shift_col[23:16]);
		s2 = sbox(shift_col[15:8]);
		s3 = sbox(shift_col[7:0]);
		all = s0 ^ s1 ^ s2 ^ s3;
		m0 = s0 ^ all ^ xtime(s0 ^ s1);
		m1 = s1 ^ all ^ xtime(s1 ^ s2);
		m2 = s2 ^ all ^ xtime(s2 ^ s3);
		m3 = s3 ^ all ^ xtime(s3 ^ s0);
		nxt = ctrl.mix ? {m0, m1, m2, m3} : {s0, s1, s2, s3};
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			col_q <= load_col ^ rkey;
		end else if (ctrl.step) begin
			col_q <= nxt ^ rkey;
		end
	end
endmodule

[rtl/aesbe_key_sched.sv]
// key expansion, one 32-bit word a cycle, into the round key memory
module aesbe_key_sched (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [3:0][aesbe_pkg::KeyRegW-1:0]   key_regs,
	input  logic [aesbe_pkg::KeyLenW-1:0]        key_len,
	input  logic [aesbe_pkg::RkIdxW-1:0]         rd_idx,
	output logic [aesbe_pkg::KeyRegW-1:0]        rd_data_q,
	output logic                                 busy
);
	import aesbe_pkg::*;

	logic [63:0] rk_mem [RkDepth];
	logic [31:0] win_q [8];
	logic [5:0] i_q, total;
	logic [3:0] nk, pos_q;
	logic [7:0] rcon_q;
	logic run_q;
	logic [31:0] t, neww;

	assign nk = (key_len == Len128) ? 4'd4 : (key_len == Len192) ? 4'd6 : 4'd8;
	assign total = (key_len == Len128) ? 6'd44 : (key_len == Len192) ? 6'd52 : 6'd60;
	assign busy = run_q;

	always_comb begin
		t = win_q[7];
		if (pos_q == 4'd0) begin
			t = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && pos_q == 4'd4) begin
			t = sub_word(win_q[7]);
		end
		neww = win_q[3'(4'd8 - nk)] ^ t;
	end

	// window of the last nk words, newest in the top slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= '0;
			pos_q <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			run_q <= 1'b1;
			i_q <= 6'(nk);
			pos_q <= '0;
			rcon_q <= 8'h01;
		end else if (run_q) begin
			if (i_q == total - 6'd1) begin
				run_q <= 1'b0;
			end
			i_q <= i_q + 6'd1;
			pos_q <= (pos_q == nk - 4'd1) ? 4'd0 : pos_q + 4'd1;
			if (pos_q == 4'd0) begin
				rcon_q <= xtime(rcon_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < 8; k++) begin
				if (k >= 8 - int'(nk)) begin
					win_q[k] <= key_regs[(k - (8 - int'(nk))) / 2][((k - (8 - int'(nk))) % 2 == 0) ? 32 : 0 +: 32];
				end else begin
					win_q[k] <= '0;
				end
			end
		end else if (run_q) begin
			for (int k = 0; k < 7; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[7] <= neww;
		end
		if (start) begin
			for (int k = 0; k < 4; k++) begin
				if (k < int'(nk) / 2) begin
					rk_mem[k] <= key_regs[k];
				end
			end
		end else if (run_q && i_q[0]) begin
			rk_mem[RkIdxW'(i_q[5:1])] <= {win_q[7], neww};
		end
		rd_data_q <= rk_mem[rd_idx];
	end
endmodule

[rtl/aes_block_encrypt_unit.sv]
// top level of the aes block encryptor: control, column cells and key schedule
//  channel | signals                      | words
//  cfg     | cfg_we, cfg_idx, cfg_data    | key words 0..3, key length
//  s_axis  | tvalid, tready, tdata[127:0] | plaintext in
//  m_axis  | tvalid, tready, tdata[127:0] | ciphertext out
// after a key change the first word first waits for the key expansion
// each word then runs its rounds, each round reading its round key from the memory in two halves,
// and the result is shown once the last round has landed
// input is held off until the result is taken; the next word can be taken from the cycle after
// reset clears control and the config registers, not the column registers; the result waits there until taken
module aes_block_encrypt_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [aesbe_pkg::CfgIdxW-1:0]     cfg_idx,
	input  logic [aesbe_pkg::KeyRegW-1:0]     cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// plain_high [63:0], plain_low [127:64]
	input  logic [127:0]                      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// cipher_high [63:0], cipher_low [127:64]
	output logic [127:0]                      m_axis_tdata
);
	import aesbe_pkg::*;

	logic [3:0][KeyRegW-1:0] key_q;
	logic [KeyLenW-1:0] klen_q;
	logic ready_q;
	state_t st_q;
	logic [3:0] rnd_q, nr;
	logic half_q;
	logic [63:0] rk_hi_q, rd_data;
	logic [RkIdxW-1:0] rd_idx;
	logic ks_busy, ks_start;
	logic [127:0] blk_q;
	logic [31:0] col [NumCols];
	logic [31:0] shf [NumCols];
	logic [127:0] rk, stv;
	col_ctrl_t ctrl;
	logic apply_q;
	logic [3:0] arnd_q;

	assign nr = (klen_q == Len128) ? 4'd10 : (klen_q == Len192) ? 4'd12 : 4'd14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			klen_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegKey0: key_q[0] <= cfg_data;
				RegKey1: key_q[1] <= cfg_data;
				RegKey2: key_q[2] <= cfg_data;
				RegKey3: key_q[3] <= cfg_data;
				RegKeyLen: klen_q <= (cfg_data[KeyLenW-1:0] == LenSpare) ? Len256
					: cfg_data[KeyLenW-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (st_q == ST_IDLE);
	// the last round is still being applied when the done state is entered; valid waits until it has landed
	assign m_axis_tvalid = (st_q == ST_DONE) && !apply_q;
	assign ks_start = (st_q == ST_IDLE) && s_axis_tvalid && !ready_q;
	// read two halves per round: high half the cycle before the low one
	assign rd_idx = RkIdxW'({rnd_q, half_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ready_q <= 1'b0;
			rnd_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (cfg_we && int'(cfg_idx) < NumCfgRegs) begin
				ready_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						st_q <= ready_q ? ST_ROUND : ST_KEXP;
						rnd_q <= '0;
						half_q <= 1'b0;
					end
				end
				ST_KEXP: begin
					if (!ks_busy) begin
						ready_q <= 1'b1;
						st_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					half_q <= ~half_q;
					if (half_q) begin
						if (rnd_q == nr) begin
							st_q <= ST_DONE;
						end
						rnd_q <= rnd_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (m_axis_tready && !apply_q) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_axis_tvalid) begin
			blk_q <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
		end
		rk_hi_q <= rd_data;
	end

	aesbe_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .start(ks_start), .key_regs(key_q),
		.key_len(klen_q), .rd_idx(rd_idx), .rd_data_q(rd_data), .busy(ks_busy)
	);

	// data is registered in the memory and lands the cycle after the address; the low half comes with half_q low again
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apply_q <= 1'b0;
			arnd_q <= '0;
		end else begin
			apply_q <= (st_q == ST_ROUND) && half_q;
			arnd_q <= rnd_q;
		end
	end

	assign rk = {rk_hi_q, rd_data};
	assign ctrl.load = apply_q && (arnd_q == 4'd0);
	assign ctrl.step = apply_q && (arnd_q != 4'd0);
	assign ctrl.mix = (arnd_q != nr);

	always_comb begin
		for (int c = 0; c < NumCols; c++) begin
			for (int r = 0; r < 4; r++) begin
				shf[c][31-8*r -: 8] = col[(c + r) % NumCols][31-8*r -: 8];
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < NumCols; g++) begin : g_col
			aesbe_col_cell u_cell (
				.clk(clk), .ctrl(ctrl), .load_col(blk_q[127-32*g -: 32]),
				.shift_col(shf[g]), .rkey(rk[127-32*g -: 32]), .col_q(col[g])
			);
			assign stv[127-32*g -: 32] = col[g];
		end
	endgenerate

	assign m_axis_tdata = {stv[63:0], stv[127:64]};
endmodule
